FILE: src/rrs_pkg.sv
// Shared types and constants for the round-robin CPU scheduler.
// Used by rrs_ready_queue and round_robin_cpu_scheduler_unit; no dependencies.
package rrs_pkg;

  localparam int PID_W   = 16;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int QUANT_W = 16;
  localparam int SWCNT_W = 16;

  localparam int MAX_PROCS_DEF = 16;

  localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd2;

  // Request codes on in_req_type and out_result_kind.
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Everything the scheduler tracks for one process.
  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  arrival;
    logic [TIME_W-1:0]  start_tick;
    logic               started;
  } proc_rec_t;

  // Queue control from the scheduler core.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage

FILE: src/rrs_ready_queue.sv
// Ready queue of process records: a shifting queue whose head is always entry 0.
// Depends on rrs_pkg for the record and control types.
module rrs_ready_queue #(
  parameter int DEPTH = rrs_pkg::MAX_PROCS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rrs_pkg::q_ctl_t            ctl,
  input  rrs_pkg::proc_rec_t         push_rec,
  output rrs_pkg::proc_rec_t         head_rec,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import rrs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  proc_rec_t        ent_r   [DEPTH];
  proc_rec_t        ent_nxt [DEPTH];
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [CW-1:0]    wr_idx;
  logic             do_pop;
  logic             do_push;

  always_comb begin
    do_pop  = ctl.pop && (count_r != '0);
    // A push into a full queue is dropped unless a pop frees a place.
    do_push = ctl.push && ((count_r != CW'(DEPTH)) || do_pop);
    wr_idx  = count_r - CW'(do_pop);

    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (do_pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
    end
    if (do_push) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (wr_idx == CW'(i)) begin
          ent_nxt[i] = push_rec;
        end
      end
    end

    count_nxt = count_r - CW'(do_pop) + CW'(do_push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  assign head_rec = ent_r[0];
  assign count    = count_r;

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> count_r != '0)
    else $error("ready queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> (count_r != CW'(DEPTH)) || ctl.pop)
    else $error("ready queue pushed while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("ready queue count beyond depth");

endmodule

FILE: src/round_robin_cpu_scheduler_unit.sv
// Round-robin CPU time-slice scheduler, top level.
// Depends on rrs_pkg and rrs_ready_queue.
//
//  channel | signals                               | beat moves
//  --------+---------------------------------------+-----------------------------
//  in      | in_valid/in_ready, in_* payload       | one arrival or one tick
//  out     | out_valid/out_ready, out_* payload    | one result for each input beat
//  cfg     | cfg_we, cfg_wdata                     | time quantum write, no wait
//
// Each beat is captured in an input register and then processed into the result
// register, so the block takes one beat per cycle unless the result register is
// stalled; out_valid marks a registered result. A stalled result register holds
// the input register, which in turn drops in_ready. Reset (rst_n, synchronous)
// empties the ready queue and the process table at once; there is no clearing pass.
module round_robin_cpu_scheduler_unit #(
  parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [rrs_pkg::PID_W-1:0]   in_proc_id,
  input  logic [rrs_pkg::BURST_W-1:0] in_burst_len,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_result_kind,
  output logic                        out_accepted,
  output logic [rrs_pkg::TIME_W-1:0]  out_tick_time,
  output logic                        out_cpu_busy,
  output logic [rrs_pkg::PID_W-1:0]   out_run_pid,
  output logic                        out_finished,
  output logic                        out_preempted,
  output logic [rrs_pkg::TIME_W-1:0]  out_first_run_time,
  output logic [rrs_pkg::TIME_W-1:0]  out_completion_time,
  output logic [rrs_pkg::TIME_W-1:0]  out_turnaround,
  output logic [rrs_pkg::TIME_W-1:0]  out_response,
  output logic [rrs_pkg::SWCNT_W-1:0] out_context_switches,

  input  logic                        cfg_we,
  input  logic [rrs_pkg::QUANT_W-1:0] cfg_wdata
);
  import rrs_pkg::*;

  localparam int NF_W = $clog2(MAX_PROCS + 1);

  typedef struct packed {
    logic               kind;
    logic               accepted;
    logic [TIME_W-1:0]  tick_time;
    logic               busy;
    logic [PID_W-1:0]   pid;
    logic               finished;
    logic               preempted;
    logic [TIME_W-1:0]  start_tick;
    logic [TIME_W-1:0]  completion;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  response;
    logic [SWCNT_W-1:0] switches;
  } result_t;

  // Input register.
  logic               s1_valid_r;
  logic               s1_type_r;
  logic [PID_W-1:0]   s1_pid_r;
  logic [BURST_W-1:0] s1_burst_r;
  logic               s1_go;

  // Scheduler state.
  logic [QUANT_W-1:0] quantum_r;
  proc_rec_t          cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [QUANT_W-1:0] ql_r, ql_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [NF_W-1:0]    nf_r, nf_nxt;
  logic [PID_W-1:0]   last_pid_r, last_pid_nxt;
  logic               last_valid_r, last_valid_nxt;
  logic [SWCNT_W-1:0] sw_r, sw_nxt;

  // Result register.
  logic               out_valid_r;
  result_t            res_r, res_nxt;

  // Ready queue.
  q_ctl_t             q_ctl;
  proc_rec_t          q_push_rec;
  proc_rec_t          q_head;
  logic [NF_W-1:0]    q_count;

  proc_rec_t          run_rec;
  proc_rec_t          upd_rec;
  proc_rec_t          arr_rec;
  logic               dispatch;
  logic               fin;
  logic [QUANT_W-1:0] ql_run;
  logic [TIME_W-1:0]  comp;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  rrs_ready_queue #(
    .DEPTH (MAX_PROCS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (q_ctl),
    .push_rec (q_push_rec),
    .head_rec (q_head),
    .count    (q_count)
  );

  always_comb begin
    cur_nxt        = cur_r;
    cur_valid_nxt  = cur_valid_r;
    ql_nxt         = ql_r;
    now_nxt        = now_r;
    nf_nxt         = nf_r;
    last_pid_nxt   = last_pid_r;
    last_valid_nxt = last_valid_r;
    sw_nxt         = sw_r;
    q_ctl          = '0;

    comp     = (now_r == '1) ? now_r : now_r + TIME_W'(1);
    dispatch = !cur_valid_r && (q_count != '0);
    run_rec  = dispatch ? q_head : cur_r;
    ql_run   = dispatch ? quantum_r : ql_r;

    // The running process after one unit of work.
    upd_rec = run_rec;
    if (!run_rec.started) begin
      upd_rec.started    = 1'b1;
      upd_rec.start_tick = now_r;
    end
    if (run_rec.remaining != '0) begin
      upd_rec.remaining = run_rec.remaining - BURST_W'(1);
    end
    fin = (upd_rec.remaining == '0);

    arr_rec.pid        = s1_pid_r;
    arr_rec.remaining  = s1_burst_r;
    arr_rec.arrival    = now_r;
    arr_rec.start_tick = '0;
    arr_rec.started    = 1'b0;

    q_push_rec = (s1_type_r == REQ_ARRIVAL) ? arr_rec : upd_rec;

    res_nxt           = '0;
    res_nxt.kind      = s1_type_r;
    res_nxt.tick_time = now_r;
    res_nxt.switches  = sw_r;

    if (s1_type_r == REQ_ARRIVAL) begin
      if ((s1_burst_r != '0) && (nf_r < NF_W'(MAX_PROCS))) begin
        q_ctl.push       = s1_go;
        nf_nxt           = nf_r + NF_W'(1);
        res_nxt.accepted = 1'b1;
      end
    end else begin
      now_nxt   = comp;
      q_ctl.pop = s1_go && dispatch;
      if (cur_valid_r || dispatch) begin
        if (last_valid_r && (run_rec.pid != last_pid_r) && (sw_r != '1)) begin
          sw_nxt = sw_r + SWCNT_W'(1);
        end
        last_pid_nxt     = run_rec.pid;
        last_valid_nxt   = 1'b1;
        res_nxt.busy     = 1'b1;
        res_nxt.pid      = run_rec.pid;
        res_nxt.switches = sw_nxt;
        cur_nxt          = upd_rec;
        cur_valid_nxt    = 1'b1;
        ql_nxt           = ql_run;
        if (fin) begin
          res_nxt.finished   = 1'b1;
          res_nxt.start_tick = upd_rec.start_tick;
          res_nxt.completion = comp;
          res_nxt.turnaround = comp - upd_rec.arrival;
          res_nxt.response   = upd_rec.start_tick - upd_rec.arrival;
          cur_valid_nxt      = 1'b0;
        end else if (ql_run != '0) begin
          ql_nxt = ql_run - QUANT_W'(1);
          if (ql_run == QUANT_W'(1)) begin
            // Quantum used up: back to the tail of the ready queue.
            q_ctl.push        = s1_go;
            cur_valid_nxt     = 1'b0;
            res_nxt.preempted = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      quantum_r    <= QUANTUM_RST;
      cur_valid_r  <= 1'b0;
      ql_r         <= '0;
      now_r        <= '0;
      nf_r         <= '0;
      last_pid_r   <= '0;
      last_valid_r <= 1'b0;
      sw_r         <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      if (s1_go) begin
        cur_valid_r  <= cur_valid_nxt;
        ql_r         <= ql_nxt;
        now_r        <= now_nxt;
        nf_r         <= nf_nxt;
        last_pid_r   <= last_pid_nxt;
        last_valid_r <= last_valid_nxt;
        sw_r         <= sw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_type_r  <= in_req_type;
      s1_pid_r   <= in_proc_id;
      s1_burst_r <= in_burst_len;
    end
    if (s1_go) begin
      cur_r <= cur_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = res_r.kind;
  assign out_accepted         = res_r.accepted;
  assign out_tick_time        = res_r.tick_time;
  assign out_cpu_busy         = res_r.busy;
  assign out_run_pid          = res_r.pid;
  assign out_finished         = res_r.finished;
  assign out_preempted        = res_r.preempted;
  assign out_first_run_time   = res_r.start_tick;
  assign out_completion_time  = res_r.completion;
  assign out_turnaround       = res_r.turnaround;
  assign out_response         = res_r.response;
  assign out_context_switches = res_r.switches;

  a_sw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> sw_r >= $past(sw_r))
    else $error("context switch count went down");

  a_running_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> q_count < NF_W'(MAX_PROCS))
    else $error("running process also counted in a full ready queue");

  a_fin_xor_preempt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.finished && res_r.preempted))
    else $error("result both finished and preempted");

  a_arrival_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.kind == REQ_ARRIVAL) |-> !res_r.busy)
    else $error("arrival result reports a running process");

endmodule

FILE: tb/round_robin_cpu_scheduler_unit_tb.sv
// Self-checking testbench for the round-robin CPU scheduler top level.
// Depends on rrs_pkg and the RTL under src/. It carries its own scheduler
// predictor and compares every result beat with it, field by field.
module round_robin_cpu_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrs_pkg::*;

  localparam int NPROC       = MAX_PROCS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 4;
  localparam int PHASE_BEATS = 235;
  localparam int PRESSURE_PHASE = 2;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic               kind;
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
  } sched_req_t;

  typedef struct packed {
    logic               kind;
    logic               accepted;
    logic [TIME_W-1:0]  tick_time;
    logic               cpu_busy;
    logic [PID_W-1:0]   run_pid;
    logic               finished;
    logic               preempted;
    logic [TIME_W-1:0]  start_tick;
    logic [TIME_W-1:0]  completion;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  response;
    logic [SWCNT_W-1:0] switches;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_req_type = REQ_TICK;
  logic [PID_W-1:0]   in_proc_id = '0;
  logic [BURST_W-1:0] in_burst_len = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_result_kind;
  logic               out_accepted;
  logic [TIME_W-1:0]  out_tick_time;
  logic               out_cpu_busy;
  logic [PID_W-1:0]   out_run_pid;
  logic               out_finished;
  logic               out_preempted;
  logic [TIME_W-1:0]  out_first_run_time;
  logic [TIME_W-1:0]  out_completion_time;
  logic [TIME_W-1:0]  out_turnaround;
  logic [TIME_W-1:0]  out_response;
  logic [SWCNT_W-1:0] out_context_switches;

  logic               cfg_we = 1'b0;
  logic [QUANT_W-1:0] cfg_wdata = '0;

  round_robin_cpu_scheduler_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_proc_id          (in_proc_id),
    .in_burst_len        (in_burst_len),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_accepted        (out_accepted),
    .out_tick_time       (out_tick_time),
    .out_cpu_busy        (out_cpu_busy),
    .out_run_pid         (out_run_pid),
    .out_finished        (out_finished),
    .out_preempted       (out_preempted),
    .out_first_run_time  (out_first_run_time),
    .out_completion_time (out_completion_time),
    .out_turnaround      (out_turnaround),
    .out_response        (out_response),
    .out_context_switches(out_context_switches),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Beats waiting to be sent, and results waiting to come out.
  sched_req_t    sched_beats [$];
  sched_result_t due_outcomes [$];
  sched_req_t    next_beat;

  int mismatch_count = 0;
  int out_beats = 0;
  int idle_cycles = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 88;
  int phase_no = -1;
  int hold_left = 0;
  bit pressure_done = 1'b0;

  // Stimulus planning: the planner tracks table occupancy so that big bursts
  // only go out once the table is full and can no longer take them.
  int               planned_slots = 0;
  logic [PID_W-1:0] last_pid = '0;

  // Scheduler state as the predictor sees it.
  proc_rec_t          proc_table [NPROC];
  logic [3:0]         ready_ring [NPROC];
  int                 ring_head = 0;
  int                 ring_tail = 0;
  int                 ring_count = 0;
  int                 cur_slot = 0;
  bit                 cur_valid = 1'b0;
  logic [QUANT_W-1:0] slice_left = '0;
  logic [TIME_W-1:0]  clock_now = '0;
  int                 free_slot = 0;
  logic [PID_W-1:0]   prev_pid = '0;
  bit                 prev_valid = 1'b0;
  logic [SWCNT_W-1:0] switch_total = '0;
  logic [QUANT_W-1:0] quantum_shadow = QUANTUM_RST;

  function automatic void requeue(int slot);
    if (ring_count < NPROC) begin
      ready_ring[ring_tail] = slot[3:0];
      ring_tail = (ring_tail + 1) % NPROC;
      ring_count++;
    end
  endfunction

  function automatic sched_result_t schedule_step(logic kind, logic [PID_W-1:0] pid,
                                                  logic [BURST_W-1:0] burst);
    sched_result_t     r;
    logic [TIME_W-1:0] done_at;
    int                s;
    r = '0;
    r.kind = kind;
    r.tick_time = clock_now;
    if (kind == REQ_ARRIVAL) begin
      if (burst != 0 && free_slot < NPROC) begin
        proc_table[free_slot] = '{pid: pid, remaining: burst, arrival: clock_now,
                                  start_tick: '0, started: 1'b0};
        requeue(free_slot);
        free_slot++;
        r.accepted = 1'b1;
      end
      r.switches = switch_total;
      return r;
    end

    if (!cur_valid && ring_count != 0) begin
      cur_slot = int'(ready_ring[ring_head]);
      ring_head = (ring_head + 1) % NPROC;
      ring_count--;
      cur_valid = 1'b1;
      slice_left = quantum_shadow;
    end

    if (cur_valid) begin
      s = cur_slot;
      // Idle ticks between two runs do not break the switch chain.
      if (prev_valid && proc_table[s].pid != prev_pid && switch_total != '1)
        switch_total = switch_total + SWCNT_W'(1);
      prev_pid = proc_table[s].pid;
      prev_valid = 1'b1;
      if (!proc_table[s].started) begin
        proc_table[s].started = 1'b1;
        proc_table[s].start_tick = clock_now;
      end
      r.cpu_busy = 1'b1;
      r.run_pid = proc_table[s].pid;
      if (proc_table[s].remaining != 0)
        proc_table[s].remaining = proc_table[s].remaining - BURST_W'(1);
      if (proc_table[s].remaining == 0) begin
        done_at = (clock_now == '1) ? clock_now : clock_now + TIME_W'(1);
        r.finished = 1'b1;
        r.start_tick = proc_table[s].start_tick;
        r.completion = done_at;
        r.turnaround = done_at - proc_table[s].arrival;
        r.response = proc_table[s].start_tick - proc_table[s].arrival;
        cur_valid = 1'b0;
      end else if (slice_left != 0) begin
        slice_left = slice_left - QUANT_W'(1);
        if (slice_left == 0) begin
          requeue(s);
          cur_valid = 1'b0;
          r.preempted = 1'b1;
        end
      end
    end

    r.switches = switch_total;
    if (clock_now != '1)
      clock_now = clock_now + TIME_W'(1);
    return r;
  endfunction

  function automatic void add_tick();
    sched_req_t b;
    b.kind = REQ_TICK;
    b.pid = PID_W'($urandom);
    b.burst = BURST_W'($urandom);
    sched_beats.push_back(b);
  endfunction

  function automatic void add_arrival(logic [PID_W-1:0] pid, logic [BURST_W-1:0] burst);
    sched_req_t b;
    b.kind = REQ_ARRIVAL;
    b.pid = pid;
    b.burst = burst;
    sched_beats.push_back(b);
    if (burst != 0 && planned_slots < NPROC)
      planned_slots++;
    last_pid = pid;
  endfunction

  // Mostly ticks; arrivals reuse the previous pid now and then. At most
  // 'budget' arrivals per call are meant to be taken into the table.
  function automatic void plan_random(int count, int budget);
    int               added;
    logic [PID_W-1:0] pid;
    logic [BURST_W-1:0] burst;
    added = 0;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        pid = ($urandom_range(0, 3) == 0) ? last_pid : PID_W'($urandom);
        if (planned_slots >= NPROC) begin
          burst = BURST_W'($urandom_range(0, 65535));
        end else if (added < budget && $urandom_range(0, 2) != 0) begin
          burst = BURST_W'($urandom_range(1, 24));
          added++;
        end else begin
          burst = '0;
        end
        add_arrival(pid, burst);
      end else begin
        add_tick();
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result beat %0d, %s: got 0x%0h, want 0x%0h",
                                out_beats, name, got, want));
  endtask

  // Sampled at the falling edge, where every queue and handshake is settled.
  task automatic wait_drained();
    while (sched_beats.size() != 0 || in_valid || due_outcomes.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sched_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_beat = sched_beats.pop_front();
        in_valid <= 1'b1;
        in_req_type <= next_beat.kind;
        in_proc_id <= next_beat.pid;
        in_burst_len <= next_beat.burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // In the pressure phase the receiver stops for a long stretch so that the
  // block fills up and drops in_ready while beats keep coming.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (phase_no == PRESSURE_PHASE && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_outcomes.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                    out_beats));
        end else begin
          want = due_outcomes.pop_front();
          check_field("result_kind", 32'(out_result_kind), 32'(want.kind));
          check_field("accepted", 32'(out_accepted), 32'(want.accepted));
          check_field("tick_time", out_tick_time, want.tick_time);
          check_field("cpu_busy", 32'(out_cpu_busy), 32'(want.cpu_busy));
          check_field("run_pid", 32'(out_run_pid), 32'(want.run_pid));
          check_field("finished", 32'(out_finished), 32'(want.finished));
          check_field("preempted", 32'(out_preempted), 32'(want.preempted));
          check_field("first_run_time", out_first_run_time, want.start_tick);
          check_field("completion_time", out_completion_time, want.completion);
          check_field("turnaround", out_turnaround, want.turnaround);
          check_field("response", out_response, want.response);
          check_field("context_switches", 32'(out_context_switches),
                      32'(want.switches));
        end
        out_beats++;
      end
      if (in_valid && in_ready)
        due_outcomes.push_back(schedule_step(in_req_type, in_proc_id, in_burst_len));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("** round_robin_cpu_scheduler_unit: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [QUANT_W-1:0] phase_quantum [PHASES];
    int                 phase_send_idle [PHASES];
    int                 phase_recv_idle [PHASES];
    int                 phase_budget [PHASES];
    phase_quantum   = '{16'd0, 16'hFFFF, 16'd1, 16'd3};
    phase_send_idle = '{25, 88, 0, 0};
    phase_recv_idle = '{88, 25, 0, 0};
    phase_budget    = '{3, 3, 3, NPROC};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening at the reset quantum: an idle tick, a zero burst,
    // pid extremes, two same-pid processes back to back, preemption, and
    // an arrival while the CPU is busy.
    add_tick();
    add_arrival(16'h0000, 16'd0);
    add_arrival(16'h0000, 16'd1);
    add_arrival(16'hFFFF, 16'd3);
    add_arrival(16'hFFFF, 16'd2);
    repeat (3) add_tick();
    add_arrival(16'h8001, 16'd1);
    repeat (8) add_tick();
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = phase_send_idle[p];
      recv_idle_pct = phase_recv_idle[p];
      phase_no = p;
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= phase_quantum[p];
      quantum_shadow = phase_quantum[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      plan_random(PHASE_BEATS, phase_budget[p]);
      wait_drained();
    end

    // Then catch any stray result beat before the verdict.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("** round_robin_cpu_scheduler_unit: PASSED **");
    else
      $display("** round_robin_cpu_scheduler_unit: FAILED **");
    $finish;
  end

endmodule

FILE: round_robin_cpu_scheduler_unit.f
src/rrs_pkg.sv
src/rrs_ready_queue.sv
src/round_robin_cpu_scheduler_unit.sv
tb/round_robin_cpu_scheduler_unit_tb.sv
